// File: rtl/core/raycast_wall_texture_column_macros.svh
// Assertion macros for the raycast wall texture column block.
// Used by the top level only; needs a clock and reset in scope.
`ifndef RAYCAST_WALL_TEXTURE_COLUMN_MACROS_SVH
`define RAYCAST_WALL_TEXTURE_COLUMN_MACROS_SVH

// same-cycle implication
`define RWTC_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RWTC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/rwtc_pkg.sv
// Shared types and constants for the raycast wall texture column block.
// No dependencies.
package rwtc_pkg;

   localparam int SCREEN_HEIGHT = 1024;
   localparam int HALF_HEIGHT   = SCREEN_HEIGHT / 2;
   localparam int DIV_W         = 28;
   localparam int CNT_W         = $clog2(DIV_W + 1);
   localparam int ROW_W         = 11;
   localparam int REG_W         = 11;
   localparam int NUM_REGS      = 8;
   localparam int ADDR_W        = 3;
   localparam int Q_W           = 32;
   localparam logic [REG_W-1:0] REG_RESET = REG_W'(64);

   localparam logic KIND_SETUP = 1'b0;
   localparam logic KIND_ROW   = 1'b1;

   typedef struct packed {
      logic setup;
      logic row;
      logic div_start;
      logic calc;
      logic fin;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic row_live;
   } status_type;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_DIV1 = 5'b00010,
      ST_CALC = 5'b00100,
      ST_DIV2 = 5'b01000,
      ST_FIN  = 5'b10000
   } state_type;

   function automatic logic [ADDR_W-1:0] height_idx(input logic [1:0] face);
      height_idx = {face, 1'b0};
   endfunction

   function automatic logic [ADDR_W-1:0] width_idx(input logic [1:0] face);
      width_idx = {face, 1'b1};
   endfunction

endpackage

// File: rtl/core/rwtc_div.sv
// Restoring serial divider, one quotient bit per cycle.
// Depends on rwtc_pkg.
module rwtc_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [rwtc_pkg::DIV_W-1:0] num,
   input  logic [rwtc_pkg::DIV_W-1:0] den,
   output logic [rwtc_pkg::DIV_W-1:0] quo,
   output logic                      done
);
   import rwtc_pkg::*;

   logic [DIV_W-1:0] rem_ff, rem_in, quo_ff, quo_in, den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in, done_ff, done_in;
   logic [DIV_W:0]   trial, diff;
   logic             ge;

   always_comb begin
      trial   = {rem_ff, quo_ff[DIV_W-1]};
      diff    = trial - {1'b0, den_ff};
      ge      = trial >= {1'b0, den_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = num;
         den_in  = den;
         cnt_in  = CNT_W'(DIV_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
         quo_in = {quo_ff[DIV_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quo  = quo_ff;
   assign done = done_ff;

endmodule

// File: rtl/core/rwtc_dp.sv
// Datapath: face registers, setup arithmetic, held column state, output item.
// Depends on rwtc_pkg and rwtc_div.
module rwtc_dp (
   input  logic                        clock,
   input  logic                        reset,
   input  rwtc_pkg::cmd_type           cmd,
   output rwtc_pkg::status_type        status,
   input  logic [127:0]                req_tdata,
   input  logic                        csr_we,
   input  logic [rwtc_pkg::ADDR_W-1:0] csr_addr,
   input  logic [rwtc_pkg::REG_W-1:0]  csr_wdata,
   output logic [47:0]                 rsp_tdata,
   output logic                        rsp_tlast
);
   import rwtc_pkg::*;

   localparam logic [DIV_W-1:0] LEN_NUM = DIV_W'(SCREEN_HEIGHT * 65536);

   logic [REG_W-1:0] cfg_ff [NUM_REGS];

   logic [11:0]      in_col;
   logic             in_side;
   logic signed [17:0] in_dx, in_dy;
   logic [23:0]      in_ex, in_ey;
   logic [27:0]      in_dist;

   logic [1:0]       face_in, face_ff;
   logic [11:0]      col_ff;
   logic [15:0]      frac_ff, frac_in;
   logic [DIV_W-1:0] dist_nz;
   logic signed [46:0] prod;

   logic [DIV_W-1:0] div_num, div_den, div_quo;
   logic             div_done;

   logic [DIV_W-2:0] half_len;
   logic [DIV_W-1:0] last_sum;
   logic [ROW_W-1:0] first_in, last_in, first_ff, last_ff;
   logic             empty_in, empty_ff;
   logic [Q_W-1:0]   offset_in, offset_ff;
   logic [26:0]      texel_prod;
   logic [9:0]       texel_ff;

   logic [Q_W-1:0]   step_in, pos_prod;
   logic [Q_W-1:0]   pos_ff, step_ff;
   logic [ROW_W-1:0] cur_ff, end_ff;
   logic [9:0]       held_tx_ff;
   logic [1:0]       held_face_ff;
   logic [11:0]      held_col_ff;

   logic [REG_W-1:0] row_h, mask;
   logic [ROW_W:0]   cur_next;
   logic [47:0]      out_ff;
   logic             out_last_ff;

   assign in_col  = req_tdata[11:0];
   assign in_side = req_tdata[12];
   assign in_dx   = req_tdata[30:13];
   assign in_dy   = req_tdata[48:31];
   assign in_ex   = req_tdata[72:49];
   assign in_ey   = req_tdata[96:73];
   assign in_dist = req_tdata[124:97];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) cfg_ff[i] <= REG_RESET;
      end else if (csr_we) begin
         cfg_ff[csr_addr] <= csr_wdata;
      end
   end

   // setup load
   always_comb begin
      if (in_side && in_dy[17])
         face_in = 2'd0;
      else if (in_side && in_dy != '0)
         face_in = 2'd1;
      else if (!in_side && in_dx[17])
         face_in = 2'd2;
      else
         face_in = 2'd3;
      dist_nz = (in_dist == '0) ? DIV_W'(1) : in_dist;
      prod    = $signed({1'b0, dist_nz}) * (in_side ? in_dx : in_dy);
      frac_in = prod[31:16] + (in_side ? in_ex[15:0] : in_ey[15:0]);
   end

   // span and offset from the line length, texture column from the wall fraction
   always_comb begin
      half_len   = div_quo[DIV_W-1:1];
      last_sum   = {1'b0, half_len} + DIV_W'(HALF_HEIGHT);
      if (half_len < (DIV_W-1)'(HALF_HEIGHT)) begin
         first_in  = ROW_W'(HALF_HEIGHT) - half_len[ROW_W-1:0];
         offset_in = '0;
      end else begin
         first_in  = '0;
         offset_in = Q_W'(half_len - (DIV_W-1)'(HALF_HEIGHT));
      end
      last_in    = (last_sum >= DIV_W'(SCREEN_HEIGHT)) ? ROW_W'(SCREEN_HEIGHT - 1)
                                                      : last_sum[ROW_W-1:0];
      empty_in   = (div_quo == '0) || (first_in >= last_in);
      texel_prod = frac_ff * cfg_ff[width_idx(face_ff)];
   end

   assign div_num = cmd.calc ? {1'b0, cfg_ff[height_idx(face_ff)], 16'b0}
                             : LEN_NUM;
   assign div_den = cmd.calc ? div_quo : dist_nz;

   rwtc_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .den   (div_den),
      .quo   (div_quo),
      .done  (div_done)
   );

   assign step_in  = empty_ff ? '0 : Q_W'(div_quo);
   assign pos_prod = Q_W'(offset_ff * step_in);

   always_ff @(posedge clock) begin
      if (cmd.setup) begin
         face_ff <= face_in;
         col_ff  <= in_col;
         frac_ff <= frac_in;
      end
      if (cmd.calc) begin
         first_ff  <= first_in;
         last_ff   <= last_in;
         empty_ff  <= empty_in;
         offset_ff <= offset_in;
         texel_ff  <= texel_prod[25:16];
      end
   end

   // rows
   always_comb begin
      row_h    = cfg_ff[height_idx(held_face_ff)];
      mask     = row_h - 1'b1;
      cur_next = {1'b0, cur_ff} + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         step_ff      <= '0;
         cur_ff       <= '0;
         end_ff       <= '0;
         held_tx_ff   <= '0;
         held_face_ff <= '0;
         held_col_ff  <= '0;
      end else if (cmd.fin) begin
         pos_ff       <= empty_ff ? '0 : pos_prod;
         step_ff      <= step_in;
         cur_ff       <= first_ff;
         end_ff       <= last_ff;
         held_tx_ff   <= texel_ff;
         held_face_ff <= face_ff;
         held_col_ff  <= col_ff;
      end else if (cmd.row) begin
         pos_ff <= pos_ff + step_ff;
         cur_ff <= cur_next[ROW_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.row) begin
         out_ff <= {4'b0, pos_ff[25:16] & mask[9:0], held_tx_ff, held_face_ff,
                    cur_ff[9:0], held_col_ff};
         out_last_ff <= (cur_next == {1'b0, end_ff});
      end
   end

   assign status.div_done = div_done;
   assign status.row_live = cur_ff < end_ff;
   assign rsp_tdata       = out_ff;
   assign rsp_tlast       = out_last_ff;

endmodule

// File: rtl/core/rwtc_ctrl.sv
// Controller: input handshake, setup sequencing, output valid.
// Depends on rwtc_pkg.
module rwtc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic                 req_tuser,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output rwtc_pkg::cmd_type    cmd,
   input  rwtc_pkg::status_type status
);
   import rwtc_pkg::*;

   state_type state_ff, state_in;
   logic      valid_ff, valid_in, accept;

   assign req_tready = (state_ff == ST_IDLE) && (!valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      cmd.setup     = accept && (req_tuser == KIND_SETUP);
      cmd.row       = accept && (req_tuser == KIND_ROW) && status.row_live;
      cmd.calc      = (state_ff == ST_CALC);
      cmd.fin       = (state_ff == ST_FIN);
      cmd.div_start = cmd.setup || cmd.calc;
      state_in      = state_ff;
      unique case (state_ff)
         ST_IDLE: if (cmd.setup) state_in = ST_DIV1;
         ST_DIV1: if (status.div_done) state_in = ST_CALC;
         ST_CALC: state_in = ST_DIV2;
         ST_DIV2: if (status.div_done) state_in = ST_FIN;
         ST_FIN:  state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
      if (cmd.row)
         valid_in = 1'b1;
      else if (rsp_tready)
         valid_in = 1'b0;
      else
         valid_in = valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_tvalid = valid_ff;

endmodule

// File: rtl/core/raycast_wall_texture_column.sv
// Textured wall column stepper. A row item (tuser high) yields one pixel item
// while it lies inside the span; the output register lets the next row enter
// in the cycle the previous item leaves. A setup item holds off new items while
// the shared 28-step serial divider runs once for the line length and
// once for the texture step. Depends on rwtc_pkg, rwtc_ctrl, rwtc_dp.
`include "raycast_wall_texture_column_macros.svh"
module raycast_wall_texture_column (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // screen_column, hit_side, dir_x, dir_y, eye_x, eye_y, wall_distance
   input  logic [127:0]                req_tdata,
   // kind
   input  logic                        req_tuser,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // out_column, out_row, face_index, texel_x, texel_y
   output logic [47:0]                 rsp_tdata,
   output logic                        rsp_tlast,
   input  logic                        csr_we,
   input  logic [rwtc_pkg::ADDR_W-1:0] csr_addr,
   input  logic [rwtc_pkg::REG_W-1:0]  csr_wdata
);
   import rwtc_pkg::*;

   cmd_type    cmd;
   status_type status;

   rwtc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   rwtc_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_tdata (req_tdata),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

   `RWTC_ASSERT_NEXT(a_setup_busy, req_tvalid && req_tready && req_tuser == KIND_SETUP, !req_tready, "ready during setup")
   `RWTC_ASSERT_IMPL(a_rsp_from_row, $rose(rsp_tvalid), $past(req_tvalid && req_tready && req_tuser == KIND_ROW), "item without row")
   `RWTC_ASSERT_NEXT(a_no_setup_rsp, req_tvalid && req_tready && req_tuser == KIND_SETUP && !rsp_tvalid, !rsp_tvalid, "item from setup")

endmodule

// File: test/tb_raycast_wall_texture_column.sv
// Testbench for raycast_wall_texture_column: random and directed column setups and row
// items against a scoreboard that predicts every pixel item. Depends on rwtc_pkg and the RTL.
`timescale 1ns / 1ps

typedef struct {
   logic [11:0] column;
   logic [9:0]  row;
   logic [1:0]  face;
   logic [9:0]  texel_x;
   logic [9:0]  texel_y;
   logic        last;
} pixel_type;

class column_scoreboard;
   logic [10:0] face_regs[8];
   logic [31:0] tex_position, tex_step;
   logic [10:0] current_row, end_row;
   logic [9:0]  held_texel_x;
   logic [1:0]  held_face;
   logic [11:0] held_column;
   pixel_type   pending_pixels[$];
   int          errors;

   function new();
      for (int i = 0; i < 8; i++) face_regs[i] = rwtc_pkg::REG_RESET;
      tex_position = 0; tex_step = 0; current_row = 0; end_row = 0;
      held_texel_x = 0; held_face = 0; held_column = 0; errors = 0;
   endfunction

   function void write_reg(int idx, logic [10:0] value);
      face_regs[idx] = value;
   endfunction

   function int rows_left();
      return (current_row < end_row) ? int'(end_row - current_row) : 0;
   endfunction

   function void note_item(logic kind, logic [127:0] d);
      logic [63:0]        wall_dist, len, prod, frac, offset, eye, h, w;
      logic signed [63:0] sdir;
      logic [31:0]        half_len, first, last, mask;
      logic [17:0]        dx, dy;
      logic               side;
      pixel_type          px;
      if (kind == rwtc_pkg::KIND_SETUP) begin
         side = d[12]; dx = d[30:13]; dy = d[48:31];
         wall_dist = 64'(d[124:97]);
         if (side && dy[17]) held_face = 2'd0;
         else if (side && dy != 0) held_face = 2'd1;
         else if (!side && dx[17]) held_face = 2'd2;
         else held_face = 2'd3;
         h = 64'(face_regs[{held_face, 1'b0}]);
         w = 64'(face_regs[{held_face, 1'b1}]);
         if (wall_dist == 0) wall_dist = 1;
         len = (64'(rwtc_pkg::SCREEN_HEIGHT) << 16) / wall_dist;
         half_len = 32'(len / 2);
         first = (half_len >= rwtc_pkg::HALF_HEIGHT) ? 0 : rwtc_pkg::HALF_HEIGHT - half_len;
         last = (64'(half_len) + rwtc_pkg::HALF_HEIGHT >= rwtc_pkg::SCREEN_HEIGHT)
                ? rwtc_pkg::SCREEN_HEIGHT - 1 : half_len + rwtc_pkg::HALF_HEIGHT;
         sdir = side ? {{46{dx[17]}}, dx} : {{46{dy[17]}}, dy};
         eye = side ? 64'(d[72:49]) : 64'(d[96:73]);
         prod = wall_dist * sdir;
         frac = ((prod >> 16) + eye) & 64'hFFFF;
         held_texel_x = 10'((frac * w) >> 16);
         held_column = d[11:0];
         current_row = first[10:0];
         end_row = last[10:0];
         if (len == 0 || first >= last) begin
            tex_step = 0; tex_position = 0;
         end else begin
            tex_step = 32'((h << 16) / len);
            offset = 64'(first) + half_len - rwtc_pkg::HALF_HEIGHT;
            tex_position = 32'(offset * tex_step);
         end
      end else if (current_row < end_row) begin
         mask = (32'(face_regs[{held_face, 1'b0}]) - 1) & 32'h3FF;
         px.column = held_column;
         px.row = current_row[9:0];
         px.face = held_face;
         px.texel_x = held_texel_x;
         px.texel_y = 10'((tex_position >> 16) & mask);
         px.last = (current_row + 11'd1 == end_row);
         pending_pixels.push_back(px);
         tex_position += tex_step;
         current_row += 11'd1;
      end
   endfunction

   function void check_pixel(logic [47:0] d, logic last);
      pixel_type e;
      if (pending_pixels.size() == 0) begin
         $display("%0t: unexpected item data %h last %b", $time, d, last);
         errors++;
         return;
      end
      e = pending_pixels.pop_front();
      if (d[11:0] !== e.column) begin
         $display("%0t: column exp %0d got %0d", $time, e.column, d[11:0]); errors++;
      end
      if (d[21:12] !== e.row) begin
         $display("%0t: row exp %0d got %0d", $time, e.row, d[21:12]); errors++;
      end
      if (d[23:22] !== e.face) begin
         $display("%0t: face exp %0d got %0d", $time, e.face, d[23:22]); errors++;
      end
      if (d[33:24] !== e.texel_x) begin
         $display("%0t: texel_x exp %0d got %0d", $time, e.texel_x, d[33:24]); errors++;
      end
      if (d[43:34] !== e.texel_y) begin
         $display("%0t: texel_y exp %0d got %0d", $time, e.texel_y, d[43:34]); errors++;
      end
      if (last !== e.last) begin
         $display("%0t: last exp %b got %b", $time, e.last, last); errors++;
      end
   endfunction
endclass

module tb_raycast_wall_texture_column;
   import rwtc_pkg::*;

   localparam int FACE0_HEIGHT = 0, FACE0_WIDTH = 1, FACE1_HEIGHT = 2, FACE1_WIDTH = 3;
   localparam int FACE2_HEIGHT = 4, FACE2_WIDTH = 5, FACE3_HEIGHT = 6, FACE3_WIDTH = 7;
   localparam int SETTLE_CYCLES = 150;

   logic              clock = 0, reset = 1;
   logic              req_tvalid = 0, req_tready, req_tuser = 0;
   logic [127:0]      req_tdata = '0;
   logic              rsp_tvalid, rsp_tready = 0, rsp_tlast;
   logic [47:0]       rsp_tdata;
   logic              csr_we = 0;
   logic [ADDR_W-1:0] csr_addr = '0;
   logic [REG_W-1:0]  csr_wdata = '0;

   column_scoreboard sb = new();
   int burst_left = 0, random_items = 0, stall_mode = 0;

   raycast_wall_texture_column u_top (.*);

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_pixel(rsp_tdata, rsp_tlast);
      if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 3) != 0);
         2: rsp_tready <= 1'($urandom_range(0, 1));
         default: rsp_tready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   task automatic send_item(logic kind, logic [127:0] d);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= d;
      do @(posedge clock); while (!req_tready);
      sb.note_item(kind, d);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 12);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic send_setup(logic side, logic [17:0] dx, logic [17:0] dy,
                             logic [23:0] ex, logic [23:0] ey, logic [27:0] wall_dist,
                             logic [11:0] col);
      send_item(KIND_SETUP, {3'b0, wall_dist, ey, ex, dy, dx, side, col});
   endtask

   task automatic send_rows(int n);
      for (int i = 0; i < n; i++) send_item(KIND_ROW, 128'($urandom()));
   endtask

   task automatic drain();
      if (req_tvalid) req_tvalid <= 1'b0;
      while (sb.pending_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // leaves the write enable high; the caller drops it after the last write
   task automatic write_reg(int idx, logic [REG_W-1:0] value);
      csr_we <= 1'b1;
      csr_addr <= ADDR_W'(idx);
      csr_wdata <= value;
      @(posedge clock);
      sb.write_reg(idx, value);
   endtask

   task automatic random_setup();
      logic [27:0] wall_dist;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 85) wall_dist = 28'($urandom_range(1 << 21, 268435455));
      else if (pick < 97) wall_dist = 28'($urandom_range(1 << 16, 1 << 21));
      else wall_dist = 28'($urandom_range(0, 268435455));
      send_setup(1'($urandom_range(0, 1)), 18'($urandom()), 18'($urandom()),
                 24'($urandom()), 24'($urandom()), wall_dist, 12'($urandom()));
   endtask

   task automatic random_phase(int n);
      int rows;
      int start;
      start = random_items;
      while (random_items - start < n) begin
         random_setup();
         random_items++;
         rows = sb.rows_left();
         if (rows > 60) rows = 60;
         case ($urandom_range(0, 9))
            0: rows = $urandom_range(0, rows);
            1: rows = 0;
            default: rows = rows + $urandom_range(0, 3);
         endcase
         send_rows(rows);
         random_items += rows;
      end
   endtask

   initial begin
      #2000000;
      $display("simulation failed");
      $finish;
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: rows before any setup, extreme distances and directions
      send_rows(2);
      send_setup(1, 18'h3FFFF, 18'h20000, 24'hFFFFFF, 24'h000000, 28'd0, 12'hFFF);
      send_rows(3);
      send_setup(1, 18'h1FFFF, 18'h1FFFF, 24'h000000, 24'hFFFFFF, 28'hFFFFFFF, 12'h000);
      send_rows(2);
      send_setup(1, 18'h00000, 18'h00000, 24'h123456, 24'h654321, 28'd2621440, 12'd5);
      send_rows(4);
      send_setup(0, 18'h20000, 18'h1FFFF, 24'hABCDEF, 24'hFEDCBA, 28'd5000000, 12'd77);
      send_rows(3);
      send_setup(0, 18'h1FFFF, 18'h20000, 24'h00FFFF, 24'hFF0000, 28'd1, 12'd4000);
      send_rows(2);
      drain();

      for (int phase = 0; phase < 5; phase++) begin
         for (int r = FACE0_HEIGHT; r <= FACE3_WIDTH; r++) begin
            case (phase)
               0: write_reg(r, 11'd1);
               1: write_reg(r, 11'd1024);
               2: write_reg(r, (r % 2 == 0) ? 11'(1 << $urandom_range(0, 10))
                                            : 11'($urandom_range(1, 1024)));
               3: write_reg(r, (r % 2 == 0) ? ((r == FACE1_HEIGHT) ? 11'd0 : 11'd2047)
                                            : ((r == FACE3_WIDTH) ? 11'd2047 : 11'd0));
               default: write_reg(r, 11'($urandom()));
            endcase
         end
         csr_we <= 1'b0;
         random_phase(45);
         drain();
         random_phase(45);
         drain();
      end

      if (sb.errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/rwtc_pkg.sv
rtl/core/rwtc_div.sv
rtl/core/rwtc_dp.sv
rtl/core/rwtc_ctrl.sv
rtl/core/raycast_wall_texture_column.sv
test/tb_raycast_wall_texture_column.sv
